// ===== hw/rtl/tnrp_pkg.sv =====
// ----------------------------------------------------------------------------
// tnrp_pkg: shared types and constants of the top-K rating predictor
// Field widths, stream packing offsets, queue item and back-end state types.
// ----------------------------------------------------------------------------
`default_nettype none

package tnrp_pkg;

    localparam int MaxK   = 32;
    localparam int KW     = $clog2(MaxK);
    localparam int CntW   = $clog2(MaxK + 1);
    localparam int LimW   = 6;
    localparam int SeenW  = 11;
    localparam int RateW  = 4;
    localparam int SimInW = 16;
    localparam int SimW   = 15;
    localparam int DevW   = 16;
    localparam int MeanW  = 15;
    localparam int FbW    = 17;
    localparam int PredW  = 17;
    localparam int ProdW  = SimW + DevW + 1;
    localparam int NumW   = ProdW + KW;
    localparam int DenW   = SimW + KW;
    localparam int ScW    = NumW + CntW + 1;
    localparam int DdW    = DenW + CntW;
    localparam int DvsW   = DdW + 1;
    localparam int QW     = 16;
    localparam int QCntW  = $clog2(QW);
    localparam int RemW   = ScW + 1 - QW;

    localparam int InDataW  = 56;
    localparam int OutDataW = 32;
    localparam int OffRate  = 0;
    localparam int OffSim   = OffRate + RateW;
    localparam int OffMean  = OffSim + SimInW;
    localparam int OffFb    = OffMean + MeanW;
    localparam int OffTgt   = OffFb + FbW;

    localparam int CfgIdxW  = 2;
    localparam logic [CfgIdxW-1:0] CFG_LIMIT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_BLEND = 2'd1;

    localparam logic [LimW-1:0]  LimitReset = 6'd25;
    localparam logic [SeenW-1:0] SeenMax    = 11'd2047;

    typedef enum logic [1:0] {
        K_BEGIN = 2'd0,
        K_CAND  = 2'd1,
        K_SKIP  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic                    last;
        logic [SimW-1:0]         sim;
        logic signed [DevW-1:0]  dev;
        logic [MeanW-1:0]        mean;
        logic signed [FbW-1:0]   fb;
    } item_t;

    typedef struct packed {
        logic [LimW-1:0] limit;
        logic            blend;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_RUN   = 5'b00001,
        ST_ACC   = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tnrp_front.sv =====
// ----------------------------------------------------------------------------
// tnrp_front: request intake
// Unpack the input stream, classify each request and compute its deviation.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrp_front import tnrp_pkg::*;
(
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [InDataW-1:0] in_data,
    input  wire logic               in_user,
    input  wire logic               in_last,
    input  wire logic               q_full,
    output logic                    push,
    output item_t                   push_item
);

    logic [RateW-1:0]  rating;
    logic [SimInW-1:0] sim;
    logic [MeanW-1:0]  mean;
    logic [FbW-1:0]    fb;
    logic              tgt;
    logic              qual;

    assign rating = in_data[OffRate +: RateW];
    assign sim    = in_data[OffSim +: SimInW];
    assign mean   = in_data[OffMean +: MeanW];
    assign fb     = in_data[OffFb +: FbW];
    assign tgt    = in_data[OffTgt];

    // Qualify: positive rating, not the target, positive similarity.
    assign qual = !rating[RateW-1] && (rating != '0) && !tgt
                  && !sim[SimInW-1] && (sim != '0);

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.kind = !in_user ? K_BEGIN : (qual ? K_CAND : K_SKIP);
        push_item.last = in_last;
        push_item.sim  = sim[SimW-1:0];
        push_item.dev  = $signed({rating, 12'd0}) - $signed({1'b0, mean});
        push_item.mean = mean;
        push_item.fb   = $signed(fb);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tnrp_queue.sv =====
// ----------------------------------------------------------------------------
// tnrp_queue: two-entry request queue
// Decouple intake from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrp_queue import tnrp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output item_t      head
);

    item_t       slot_reg [2];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full       = cnt_reg == 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign head       = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tnrp_back.sv =====
// ----------------------------------------------------------------------------
// tnrp_back: sorted store, weighted sum, divider and result register
// Insert candidates, then accumulate, scale, divide and emit one result.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrp_back import tnrp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  cfg_t                     cfg,
    input  wire logic                head_valid,
    input  item_t                    head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [OutDataW-1:0]      out_data,
    output logic                     out_user
);

    logic [SimW-1:0]        sim_reg [MaxK];
    logic signed [DevW-1:0] dev_reg [MaxK];

    state_t                 st_reg, st_next;
    logic [CntW-1:0]        kept_reg;
    logic [SeenW-1:0]       seen_reg;
    logic [MeanW-1:0]       mean_reg;
    logic signed [FbW-1:0]  fb_reg;
    logic [CntW-1:0]        acc_cnt_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic                   prod_vld_reg;
    logic signed [NumW-1:0] num_reg;
    logic [DenW-1:0]        den_reg;
    logic                   fb_sel_reg;
    logic                   neg_reg;
    logic [RemW-1:0]        rem_reg;
    logic [QW-1:0]          q_reg;
    logic [QCntW-1:0]       div_cnt_reg;
    logic                   ovalid_reg;
    logic [PredW-1:0]       opred_reg;
    logic [SeenW-1:0]       ocnt_reg;
    logic                   ofb_reg;

    logic [CntW-1:0]        cap;
    logic [CntW-1:0]        kept_eff;
    logic [MaxK-1:0]        ge;
    logic [MaxK-1:0]        inr;
    logic                   drop;
    logic                   do_ins;
    logic                   acc_pop;
    logic                   scale;
    logic signed [ScW-1:0]  nn;
    logic [ScW-1:0]         mag;
    logic [DdW-1:0]         dd;
    logic [ScW:0]           dvd;
    logic [DvsW-1:0]        dvs;
    logic [RemW-1:0]        trial;
    logic                   qbit;
    logic signed [PredW-1:0] term;
    logic signed [PredW:0]  sum;
    logic [PredW-1:0]       pred;
    logic                   out_free;

    // Effective limit: zero acts as one, above MaxK clamps.
    always_comb
    begin
        if (cfg.limit == '0)
            cap = CntW'(1);
        else if (cfg.limit > LimW'(MaxK))
            cap = CntW'(MaxK);
        else
            cap = CntW'(cfg.limit);
        kept_eff = (kept_reg > cap) ? cap : kept_reg;
    end

    // Parallel compare against every kept entry; ties keep the older one ahead.
    always_comb
    begin
        for (int i = 0; i < MaxK; i++)
        begin
            inr[i] = CntW'(i) < kept_eff;
            ge[i]  = inr[i] && (sim_reg[i] >= head.sim);
        end
        drop = (kept_eff == cap) && (&(ge | ~inr));
    end

    assign pop     = (st_reg == ST_RUN) && head_valid;
    assign do_ins  = pop && (head.kind == K_CAND) && !drop;
    assign acc_pop = (st_reg == ST_ACC) && (acc_cnt_reg != kept_eff);
    assign out_free = !ovalid_reg || out_ready;

    // Scaling and divider operands.
    always_comb
    begin
        scale = cfg.blend && (seen_reg < SeenW'(cap));
        nn    = scale ? num_reg * $signed({1'b0, seen_reg[CntW-1:0]})
                      : ScW'(num_reg);
        mag   = nn[ScW-1] ? ScW'(-nn) : ScW'(nn);
        dd    = scale ? DdW'(den_reg * cap) : DdW'(den_reg);
        dvd   = {mag, 1'b0} + (ScW + 1)'(dd);
        dvs   = {dd, 1'b0};
        trial = {rem_reg[RemW-2:0], q_reg[QW-1]};
        qbit  = trial >= RemW'(dvs);
    end

    // Final result with saturation.
    always_comb
    begin
        term = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        sum  = $signed({3'b000, mean_reg}) + $signed({term[PredW-1], term});
        if (fb_sel_reg)
            pred = cfg.blend ? fb_reg : {2'b00, mean_reg};
        else if (sum[PredW] != sum[PredW-1])
            pred = sum[PredW] ? {1'b1, {(PredW-1){1'b0}}} : {1'b0, {(PredW-1){1'b1}}};
        else
            pred = sum[PredW-1:0];
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_RUN:
                if (pop && head.last)
                    st_next = ST_ACC;
            ST_ACC:
                if (!acc_pop)
                    st_next = (kept_eff == '0) ? ST_OUT : ST_SCALE;
            ST_SCALE:
                st_next = ST_DIV;
            ST_DIV:
                if (div_cnt_reg == QCntW'(QW - 1))
                    st_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    st_next = ST_RUN;
            default:
                st_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_RUN;
            kept_reg     <= '0;
            seen_reg     <= '0;
            mean_reg     <= '0;
            fb_reg       <= '0;
            acc_cnt_reg  <= '0;
            prod_vld_reg <= 1'b0;
            num_reg      <= '0;
            den_reg      <= '0;
            fb_sel_reg   <= 1'b0;
            div_cnt_reg  <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_OUT && out_free)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
            case (st_reg)
                ST_RUN:
                begin
                    if (pop)
                    begin
                        case (head.kind)
                            K_BEGIN:
                            begin
                                kept_reg <= '0;
                                seen_reg <= '0;
                                mean_reg <= head.mean;
                                fb_reg   <= head.fb;
                            end
                            K_CAND:
                            begin
                                if (seen_reg != SeenMax)
                                    seen_reg <= seen_reg + 1'b1;
                                if (do_ins && kept_eff < cap)
                                    kept_reg <= kept_eff + 1'b1;
                                else
                                    kept_reg <= kept_eff;
                            end
                            default:
                            begin
                            end
                        endcase
                        if (head.last)
                        begin
                            acc_cnt_reg  <= '0;
                            prod_vld_reg <= 1'b0;
                            num_reg      <= '0;
                            den_reg      <= '0;
                        end
                    end
                end
                ST_ACC:
                begin
                    // Pop one entry per cycle, add the previous product.
                    prod_vld_reg <= acc_pop;
                    if (prod_vld_reg)
                        num_reg <= num_reg + NumW'(prod_reg);
                    if (acc_pop)
                    begin
                        acc_cnt_reg <= acc_cnt_reg + 1'b1;
                        den_reg     <= den_reg + DenW'(sim_reg[0]);
                    end
                    fb_sel_reg <= kept_eff == '0;
                end
                ST_SCALE:
                begin
                    div_cnt_reg <= '0;
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        kept_reg   <= '0;
                        seen_reg   <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload: sorted store, product, divider and result.
    always_ff @(posedge clk)
    begin
        if (do_ins)
        begin
            if (!ge[0])
            begin
                sim_reg[0] <= head.sim;
                dev_reg[0] <= head.dev;
            end
            for (int i = 1; i < MaxK; i++)
            begin
                if (!ge[i])
                begin
                    sim_reg[i] <= ge[i-1] ? head.sim : sim_reg[i-1];
                    dev_reg[i] <= ge[i-1] ? head.dev : dev_reg[i-1];
                end
            end
        end
        else if (acc_pop)
        begin
            for (int i = 0; i < MaxK - 1; i++)
            begin
                sim_reg[i] <= sim_reg[i+1];
                dev_reg[i] <= dev_reg[i+1];
            end
        end
        if (acc_pop)
            prod_reg <= $signed({1'b0, sim_reg[0]}) * dev_reg[0];
        if (st_reg == ST_SCALE)
        begin
            neg_reg <= nn[ScW-1];
            rem_reg <= dvd[ScW:QW];
            q_reg   <= dvd[QW-1:0];
        end
        if (st_reg == ST_DIV)
        begin
            rem_reg <= qbit ? trial - RemW'(dvs) : trial;
            q_reg   <= {q_reg[QW-2:0], qbit};
        end
        if (st_reg == ST_OUT && out_free)
        begin
            opred_reg <= pred;
            ocnt_reg  <= fb_sel_reg ? '0 : seen_reg;
            ofb_reg   <= fb_sel_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = {{(OutDataW - PredW - SeenW){1'b0}}, ocnt_reg, opred_reg};
    assign out_user  = ofb_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/topk_neighbor_rating_predict.sv =====
// ----------------------------------------------------------------------------
// topk_neighbor_rating_predict: top-K user-neighbor rating prediction
// Keep the K most similar qualifying neighbors and emit a weighted prediction.
// ----------------------------------------------------------------------------
// Throughput: one candidate request per cycle in the back end's sorted store
//   while it is collecting, as are begin and skipped requests; intake stalls
//   while a finished query is accumulated, scaled, divided and output.
// Path of a final request with kept neighbors: queue, accumulate, scale,
//   16-step divider, output; with none kept: queue, accumulate check, output.
// Reset: asynchronous, active low; clears the store count, counters, loaded
//   mean and fallback; limit resets to 25 and blend mode to 1.
`default_nettype none

module topk_neighbor_rating_predict import tnrp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [3:0] neighbor_rating, [19:4] similarity, [34:20] user_mean,
    // [51:35] fallback_value, [52] is_target, zero above
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    // [0] cmd
    input  wire logic                s_axis_tuser,
    // last_user
    input  wire logic                s_axis_tlast,
    // result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [16:0] prediction, [27:17] qualified_count, zero above
    output logic [OutDataW-1:0]      m_axis_tdata,
    // [0] used_fallback
    output logic                     m_axis_tuser,
    // configuration writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [LimW-1:0]     cfg_data
);

    cfg_t   cfg_reg;
    logic   q_full;
    logic   push;
    item_t  push_item;
    logic   pop;
    logic   head_valid;
    item_t  head;

    // Configuration registers; writes to unknown indexes drop.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit <= LimitReset;
            cfg_reg.blend <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LIMIT: cfg_reg.limit <= cfg_data;
                CFG_BLEND: cfg_reg.blend <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    tnrp_front u_front
    (
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    tnrp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tnrp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== verif/tb_topk_neighbor_rating_predict.sv =====
// ----------------------------------------------------------------------------
// tb_topk_neighbor_rating_predict: self-checking bench of the top-K predictor
// Stream queries of candidate neighbors, predict every result in a scoreboard
// and compare each emitted prediction field by field, across several limit
// and blend settings and several backpressure patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_topk_neighbor_rating_predict;
    import tnrp_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd2;
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_CAND  = 1'b1;
    localparam int   DRAIN_CYCLES = 80;
    localparam int   CYCLE_LIMIT  = 600000;

    typedef struct {
        logic signed [PredW-1:0] pred;
        logic [SeenW-1:0]        count;
        logic                    fallback;
    } prediction_t;

    // Scoreboard: predicts the block and holds the predictions not yet seen.
    class rating_scoreboard;
        int          top_sim[MaxK];
        int          top_dev[MaxK];
        int          kept;
        int          seen;
        int          tmean;
        int          fb;
        int          limit;
        int          blend;
        int          errors;
        prediction_t pending[$];

        function new();
            kept = 0; seen = 0; tmean = 0; fb = 0;
            limit = 25; blend = 1; errors = 0;
        endfunction

        function int eff_limit();
            if (limit == 0) return 1;
            if (limit > MaxK) return MaxK;
            return limit;
        endfunction

        function void write_cfg(logic [CfgIdxW-1:0] idx, logic [LimW-1:0] val);
            if (idx == CFG_LIMIT) limit = val;
            else if (idx == CFG_BLEND) blend = val[0];
        endfunction

        // Round to nearest, ties away from zero.
        function longint div_round(longint num, longint den);
            longint a;
            longint q;
            a = (num < 0) ? -num : num;
            q = (2 * a + den) / (2 * den);
            return (num < 0) ? -q : q;
        endfunction

        function void keep_entry(int sim, int dev);
            int cap;
            int pos;
            int last;
            cap = eff_limit();
            if (kept > cap) kept = cap;
            pos = kept;
            while (pos > 0 && top_sim[pos-1] < sim) pos--;
            if (pos >= cap) return;
            last = (kept < cap) ? kept : cap - 1;
            for (int i = last; i > pos; i--)
            begin
                top_sim[i] = top_sim[i-1];
                top_dev[i] = top_dev[i-1];
            end
            top_sim[pos] = sim;
            top_dev[pos] = dev;
            if (kept < cap) kept++;
        endfunction

        function void close_query();
            int          k;
            int          n;
            longint      num;
            longint      den;
            longint      p;
            prediction_t r;
            k = eff_limit();
            n = (kept < k) ? kept : k;
            r.fallback = (n == 0);
            if (n == 0)
                p = blend ? fb : tmean;
            else
            begin
                num = 0; den = 0;
                for (int i = 0; i < n; i++)
                begin
                    num += longint'(top_sim[i]) * longint'(top_dev[i]);
                    den += top_sim[i];
                end
                if (blend && seen < k)
                    p = tmean + div_round(num * seen, den * k);
                else
                    p = tmean + div_round(num, den);
            end
            if (p > 65535) p = 65535;
            if (p < -65536) p = -65536;
            r.pred  = p[PredW-1:0];
            r.count = (n == 0) ? '0 : seen[SeenW-1:0];
            pending.push_back(r);
            kept = 0;
            seen = 0;
        endfunction

        function void note_request(logic cmd, logic signed [RateW-1:0] rating,
                                   logic signed [SimInW-1:0] sim,
                                   logic [MeanW-1:0] mean,
                                   logic signed [FbW-1:0] fbv,
                                   logic tgt, logic last);
            if (cmd == CMD_BEGIN)
            begin
                kept = 0; seen = 0;
                tmean = mean;
                fb = fbv;
            end
            else if (rating > 0 && !tgt && sim > 0)
            begin
                if (seen < SeenMax) seen++;
                keep_entry(sim, int'(rating) * 4096 - int'(mean));
            end
            if (last) close_query();
        endfunction

        function void check_result(logic [OutDataW-1:0] data, logic user);
            prediction_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: data %h fallback %0b", data, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[PredW-1:0] !== e.pred)
            begin
                $error("prediction: expected %0d actual %0d", e.pred,
                       $signed(data[PredW-1:0]));
                errors++;
            end
            if (data[PredW+SeenW-1:PredW] !== e.count)
            begin
                $error("qualified_count: expected %0d actual %0d", e.count,
                       data[PredW+SeenW-1:PredW]);
                errors++;
            end
            if (user !== e.fallback)
            begin
                $error("used_fallback: expected %0b actual %0b", e.fallback, user);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic                s_axis_tuser;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [LimW-1:0]     cfg_data;

    rating_scoreboard sb;
    bit  send_idle;
    bit  recv_stall;
    int  cycles;
    int  qleft;

    topk_neighbor_rating_predict dut (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: stall at random when the phase asks for it.
    always @(negedge clk)
        m_axis_tready <= recv_stall ? ($urandom_range(99) >= 73) : 1'b1;

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);

    // Drive one request; entered and left just after a falling edge.
    task automatic send_req(logic cmd, logic signed [RateW-1:0] rating,
                            logic signed [SimInW-1:0] sim, logic [MeanW-1:0] mean,
                            logic signed [FbW-1:0] fbv, logic tgt, logic last);
        while (send_idle && $urandom_range(99) < 73)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = '0;
        s_axis_tdata[OffSim-1:OffRate] = rating;
        s_axis_tdata[OffMean-1:OffSim] = sim;
        s_axis_tdata[OffFb-1:OffMean]  = mean;
        s_axis_tdata[OffTgt-1:OffFb]   = fbv;
        s_axis_tdata[OffTgt]           = tgt;
        s_axis_tuser  = cmd;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(cmd, rating, sim, mean, fbv, tgt, last);
        @(negedge clk);
    endtask

    // Hold until every prediction has arrived, then let the back end drain.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LimW-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_cfg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_candidate(logic last);
        int r;
        int s;
        r = $urandom_range(99);
        if (r < 70)
        begin
            // Well-formed qualifier; a few fixed similarities force ties.
            s = ($urandom_range(9) < 3) ? 100 * $urandom_range(1, 3)
                                        : $urandom_range(1, 32767);
            send_req(CMD_CAND, RateW'($urandom_range(1, 5)), SimInW'(s),
                     MeanW'($urandom_range(0, 20480)), FbW'($urandom), 1'b0, last);
        end
        else if (r < 85)
            send_req(CMD_CAND, RateW'($urandom), SimInW'($urandom), MeanW'($urandom),
                     FbW'($urandom), 1'($urandom), last);
        else if (r < 90)
            send_req(CMD_CAND, RateW'(-$urandom_range(0, 8)),
                     SimInW'($urandom_range(1, 32767)), MeanW'($urandom),
                     FbW'($urandom), 1'b0, last);
        else if (r < 95)
            send_req(CMD_CAND, RateW'($urandom_range(1, 7)),
                     SimInW'($urandom_range(1, 32767)), MeanW'($urandom),
                     FbW'($urandom), 1'b1, last);
        else
            send_req(CMD_CAND, RateW'($urandom_range(1, 7)),
                     SimInW'(-$urandom_range(0, 32768)), MeanW'($urandom),
                     FbW'($urandom), 1'b0, last);
    endtask

    // Random queries; an open query carries over into the next phase.
    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (qleft == 0)
            begin
                qleft = ($urandom_range(99) < 80) ? $urandom_range(0, 12)
                                                  : $urandom_range(13, 70);
                if ($urandom_range(99) < 92)
                begin
                    send_req(CMD_BEGIN, RateW'($urandom), SimInW'($urandom),
                             MeanW'($urandom), FbW'($urandom), 1'($urandom),
                             qleft == 0);
                    continue;
                end
                if (qleft == 0) qleft = 1;
            end
            qleft--;
            if ($urandom_range(99) < 2) qleft = 0;
            send_candidate(qleft == 0);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_LIMIT;
        cfg_data      = '0;
        send_idle     = 1'b0;
        recv_stall    = 1'b0;
        cycles        = 0;
        qleft         = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings, no-qualifier begin, every reject reason.
        send_req(CMD_BEGIN, 0, 0, 15'h7fff, -17'sd65536, 1'b0, 1'b1);
        send_req(CMD_CAND, 5, 32767, 0, 0, 1'b0, 1'b1);
        send_req(CMD_BEGIN, 0, 0, 4096, 17'sd65535, 1'b0, 1'b0);
        send_req(CMD_CAND, 0, 1000, 0, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, -8, 1000, 0, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, 3, 1000, 0, 0, 1'b1, 1'b0);
        send_req(CMD_CAND, 3, 0, 0, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, 3, -32768, 0, 0, 1'b0, 1'b1);
        send_req(CMD_BEGIN, 0, 0, 15'h7fff, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, 7, 32767, 0, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, 1, 500, 15'h7fff, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, 2, 500, 20480, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, 5, 500, 100, 0, 1'b0, 1'b1);
        wait_idle();
        write_reg(CFG_LIMIT, 2);
        write_reg(CFG_BLEND, 0);
        write_reg(CFG_UNUSED, 6'h3f);
        // Ties with a full store: the later equal entry is dropped.
        send_req(CMD_BEGIN, 0, 0, 8192, 4096, 1'b0, 1'b0);
        send_req(CMD_CAND, 4, 300, 0, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, 1, 300, 0, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, 5, 300, 0, 0, 1'b0, 1'b0);
        send_req(CMD_CAND, 2, 301, 0, 0, 1'b0, 1'b1);
        send_req(CMD_BEGIN, 0, 0, 1000, 0, 1'b0, 1'b1);

        // Phases of random queries over settings and backpressure patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            send_idle  = (ph % 4 == 1) || (ph % 4 == 3);
            recv_stall = (ph % 4 == 2) || (ph % 4 == 3);
            case (ph)
                0: begin write_reg(CFG_LIMIT, 25); write_reg(CFG_BLEND, 1); end
                1: write_reg(CFG_LIMIT, 1);
                2: begin write_reg(CFG_LIMIT, 32); write_reg(CFG_BLEND, 0); end
                3: write_reg(CFG_LIMIT, 0);
                4: begin write_reg(CFG_LIMIT, 63); write_reg(CFG_BLEND, 1); end
                5: write_reg(CFG_LIMIT, 7);
                6: begin write_reg(CFG_LIMIT, 3); write_reg(CFG_BLEND, 0); end
                default: begin write_reg(CFG_LIMIT, 12); write_reg(CFG_BLEND, 1); end
            endcase
            run_random(130);
            // Let the sender go quiet until the result side catches up.
            if (ph == 2) wait_idle();
            run_random(120);
        end

        wait_idle();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
